// ===== rtl/bfpa_pkg.sv =====
`timescale 1ns / 1ps

package bfpa_pkg;

    // Default sizing of the partition table
    localparam int DEF_MAX_PARTITIONS = 8;
    localparam int DEF_ADDR_BITS      = 16;
    localparam int DEF_MAX_PROCESSES  = 16;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_DEFINE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== rtl/bfpa_ifs.sv =====
`timescale 1ns / 1ps

// Command channel
interface bfpa_cmd_if #(
    parameter int IDX_W  = $clog2(bfpa_pkg::DEF_MAX_PARTITIONS),
    parameter int ADDR_W = bfpa_pkg::DEF_ADDR_BITS,
    parameter int PID_W  = $clog2(bfpa_pkg::DEF_MAX_PROCESSES)
) ();
    logic                       valid;
    logic                       ready;
    logic [bfpa_pkg::CMD_W-1:0] cmd;
    logic [IDX_W-1:0]           slot_index;
    logic [ADDR_W-1:0]          slot_base;
    logic [ADDR_W-1:0]          slot_size;
    logic [ADDR_W-1:0]          request_size;
    logic [PID_W-1:0]           process_id;

    modport source (
        output valid, cmd, slot_index, slot_base, slot_size, request_size, process_id,
        input  ready
    );
    modport sink (
        input  valid, cmd, slot_index, slot_base, slot_size, request_size, process_id,
        output ready
    );
endinterface

// Result channel
interface bfpa_res_if #(
    parameter int IDX_W  = $clog2(bfpa_pkg::DEF_MAX_PARTITIONS),
    parameter int ADDR_W = bfpa_pkg::DEF_ADDR_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic [bfpa_pkg::STATUS_W-1:0] status;
    logic [IDX_W-1:0]              chosen_index;
    logic [ADDR_W-1:0]             chosen_base;
    logic [ADDR_W-1:0]             chosen_size;

    modport source (
        output valid, status, chosen_index, chosen_base, chosen_size,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_index, chosen_base, chosen_size,
        output ready
    );
endinterface

// Register write channel
interface bfpa_cfg_if #(
    parameter int CNT_W = $clog2(bfpa_pkg::DEF_MAX_PARTITIONS + 1)
) ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] partitions_in_use;

    modport source (
        output valid, partitions_in_use,
        input  ready
    );
    modport sink (
        input  valid, partitions_in_use,
        output ready
    );
endinterface

// ===== rtl/bfpa_cell.sv =====
`timescale 1ns / 1ps

// One table entry plus one stage of the probe chain
module bfpa_cell #(
    parameter int  CELL_INDEX = 0,
    parameter int  IDX_W      = 3,
    parameter int  ADDR_W     = bfpa_pkg::DEF_ADDR_BITS,
    parameter int  PID_W      = 4,
    parameter int  CNT_W      = 4,
    parameter type probe_t    = logic,
    parameter type commit_t   = logic
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] scan_n,
    input  commit_t          commit,
    input  probe_t           up_probe,
    output probe_t           down_probe
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_INDEX);

    logic [ADDR_W-1:0] base_reg,  base_next;
    logic [ADDR_W-1:0] size_reg,  size_next;
    logic [PID_W-1:0]  owner_reg, owner_next;
    logic              owned_reg, owned_next;
    probe_t            probe_reg, probe_next;

    // Entry update and probe evaluation
    always_comb
    begin
        base_next  = base_reg;
        size_next  = size_reg;
        owner_next = owner_reg;
        owned_next = owned_reg;
        probe_next = up_probe;

        if (up_probe.valid)
        begin
            unique case (up_probe.cmd)
                bfpa_pkg::CMD_DEFINE:
                begin
                    if (up_probe.slot_index == MY_IDX)
                    begin
                        base_next  = up_probe.slot_base;
                        size_next  = up_probe.slot_size;
                        owner_next = '0;
                        owned_next = 1'b0;
                    end
                end
                bfpa_pkg::CMD_ALLOC:
                begin
                    // best fit: smaller size wins, then lower base; earlier cell keeps ties
                    if ((MY_POS < scan_n) && (size_reg >= up_probe.req_size))
                    begin
                        probe_next.big = 1'b1;
                        if (!owned_reg &&
                            (!up_probe.found ||
                             (size_reg < up_probe.best_size) ||
                             ((size_reg == up_probe.best_size) &&
                              (base_reg < up_probe.best_base))))
                        begin
                            probe_next.found     = 1'b1;
                            probe_next.best_idx  = MY_IDX;
                            probe_next.best_base = base_reg;
                            probe_next.best_size = size_reg;
                        end
                    end
                end
                bfpa_pkg::CMD_RELEASE:
                begin
                    // first owned match along the chain
                    if (!up_probe.found && owned_reg && (owner_reg == up_probe.pid))
                    begin
                        probe_next.found     = 1'b1;
                        probe_next.best_idx  = MY_IDX;
                        probe_next.best_base = base_reg;
                        probe_next.best_size = size_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // claim or free once the scan has picked this entry
        if (commit.valid && (commit.idx == MY_IDX))
        begin
            owned_next = commit.claim;
            owner_next = commit.claim ? commit.pid : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            size_reg  <= '0;
            owner_reg <= '0;
            owned_reg <= 1'b0;
            probe_reg <= '0;
        end
        else
        begin
            base_reg  <= base_next;
            size_reg  <= size_next;
            owner_reg <= owner_next;
            owned_reg <= owned_next;
            probe_reg <= probe_next;
        end
    end

    assign down_probe = probe_reg;

endmodule

// ===== rtl/best_fit_partition_allocator.sv =====
`timescale 1ns / 1ps

// Best-fit fixed-partition allocator.
// request: one transaction per command (define, allocate, release). Define
//   writes an entry's base and size and frees it; allocate claims the smallest
//   free entry that fits among the first partitions_in_use entries; release
//   frees the lowest-index entry owned by the process.
// response: exactly one transaction per command with status, index, base, size.
// setup: writes partitions_in_use (saturates at MAX_PARTITIONS); always ready;
//   the user must write it only while no command is in flight; not enforced.
// A command walks a chain of MAX_PARTITIONS cells, one cell per cycle, and the
// winner is committed as it leaves the chain. Its result then passes through
// the hold stage and the output register before the response is valid. A new
// command is taken only once the previous one has left the chain and its
// result has left the hold stage.
// While the response is stalled, one further command may run through the
// chain and park its result; request.ready then stays low until it drains.
// Reset clears every entry to base 0, size 0, free, and sets
// partitions_in_use to MAX_PARTITIONS.
module best_fit_partition_allocator #(
    parameter int MAX_PARTITIONS = bfpa_pkg::DEF_MAX_PARTITIONS,
    parameter int ADDR_BITS      = bfpa_pkg::DEF_ADDR_BITS,
    parameter int MAX_PROCESSES  = bfpa_pkg::DEF_MAX_PROCESSES
) (
    input  logic clk,
    input  logic rst_n,
    bfpa_cmd_if.sink   request,
    bfpa_res_if.source response,
    bfpa_cfg_if.sink   setup
);

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int PID_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W = $clog2(MAX_PARTITIONS + 1);

    localparam logic [CNT_W-1:0] SCAN_MAX   = CNT_W'(MAX_PARTITIONS);
    localparam logic [IDX_W:0]   TABLE_SIZE = (IDX_W + 1)'(MAX_PARTITIONS);

    typedef struct packed {
        logic                       valid;
        logic [bfpa_pkg::CMD_W-1:0] cmd;
        logic [IDX_W-1:0]           slot_index;
        logic [ADDR_BITS-1:0]       slot_base;
        logic [ADDR_BITS-1:0]       slot_size;
        logic [ADDR_BITS-1:0]       req_size;
        logic [PID_W-1:0]           pid;
        logic                       found;
        logic                       big;
        logic [IDX_W-1:0]           best_idx;
        logic [ADDR_BITS-1:0]       best_base;
        logic [ADDR_BITS-1:0]       best_size;
    } probe_t;

    typedef struct packed {
        logic             valid;
        logic             claim;
        logic [IDX_W-1:0] idx;
        logic [PID_W-1:0] pid;
    } commit_t;

    typedef struct packed {
        logic [bfpa_pkg::STATUS_W-1:0] status;
        logic [IDX_W-1:0]              idx;
        logic [ADDR_BITS-1:0]          base;
        logic [ADDR_BITS-1:0]          size;
    } result_t;

    probe_t  chain [0:MAX_PARTITIONS];
    probe_t  tail;
    commit_t commit;
    result_t tail_result;

    logic             accept;
    logic             move;
    logic             busy_reg,       busy_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          pend_reg,       pend_next;
    logic             out_valid_reg,  out_valid_next;
    result_t          out_reg,        out_next;
    logic [CNT_W-1:0] scan_n_reg,     scan_n_next;

    // Command entry into the chain
    assign request.ready = !busy_reg && !pend_valid_reg;
    assign accept        = request.valid && request.ready;

    always_comb
    begin
        chain[0]            = '0;
        chain[0].valid      = accept;
        chain[0].cmd        = request.cmd;
        chain[0].slot_index = request.slot_index;
        chain[0].slot_base  = request.slot_base;
        chain[0].slot_size  = request.slot_size;
        chain[0].req_size   = request.request_size;
        chain[0].pid        = request.process_id;
    end

    // Cell chain
    for (genvar g = 0; g < MAX_PARTITIONS; g++)
    begin : g_cell
        bfpa_cell #(
            .CELL_INDEX (g),
            .IDX_W      (IDX_W),
            .ADDR_W     (ADDR_BITS),
            .PID_W      (PID_W),
            .CNT_W      (CNT_W),
            .probe_t    (probe_t),
            .commit_t   (commit_t)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .scan_n     (scan_n_reg),
            .commit     (commit),
            .up_probe   (chain[g]),
            .down_probe (chain[g+1])
        );
    end

    assign tail = chain[MAX_PARTITIONS];

    // Commit the winner to its cell as the probe leaves the chain
    always_comb
    begin
        commit.valid = tail.valid && tail.found &&
                       ((tail.cmd == bfpa_pkg::CMD_ALLOC) ||
                        (tail.cmd == bfpa_pkg::CMD_RELEASE));
        commit.claim = (tail.cmd == bfpa_pkg::CMD_ALLOC);
        commit.idx   = tail.best_idx;
        commit.pid   = tail.pid;
    end

    // Result decode
    always_comb
    begin
        tail_result = '0;
        unique case (tail.cmd)
            bfpa_pkg::CMD_DEFINE:
            begin
                tail_result.status = bfpa_pkg::ST_OK;
                if ({1'b0, tail.slot_index} < TABLE_SIZE)
                begin
                    tail_result.idx  = tail.slot_index;
                    tail_result.base = tail.slot_base;
                    tail_result.size = tail.slot_size;
                end
            end
            bfpa_pkg::CMD_ALLOC:
            begin
                if (tail.found)
                begin
                    tail_result.status = bfpa_pkg::ST_OK;
                    tail_result.idx    = tail.best_idx;
                    tail_result.base   = tail.best_base;
                    tail_result.size   = tail.best_size;
                end
                else
                begin
                    tail_result.status = tail.big ? bfpa_pkg::ST_FULL : bfpa_pkg::ST_TOO_BIG;
                end
            end
            bfpa_pkg::CMD_RELEASE:
            begin
                if (tail.found)
                begin
                    tail_result.status = bfpa_pkg::ST_OK;
                    tail_result.idx    = tail.best_idx;
                    tail_result.base   = tail.best_base;
                    tail_result.size   = tail.best_size;
                end
                else
                begin
                    tail_result.status = bfpa_pkg::ST_NOT_FOUND;
                end
            end
            default:
            begin
                tail_result.status = bfpa_pkg::ST_OK;
            end
        endcase
    end

    // Hold stage and output register
    assign move = pend_valid_reg && (!out_valid_reg || response.ready);

    always_comb
    begin
        busy_next       = busy_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end
        if (tail.valid)
        begin
            busy_next       = 1'b0;
            pend_valid_next = 1'b1;
            pend_next       = tail_result;
        end

        if (move)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Scan count register, saturated on write
    assign setup.ready = 1'b1;

    always_comb
    begin
        scan_n_next = scan_n_reg;
        if (setup.valid)
        begin
            scan_n_next = (setup.partitions_in_use > SCAN_MAX) ? SCAN_MAX
                                                               : setup.partitions_in_use;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_n_reg     <= SCAN_MAX;
        end
        else
        begin
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            scan_n_reg     <= scan_n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign response.valid        = out_valid_reg;
    assign response.status       = out_reg.status;
    assign response.chosen_index = out_reg.idx;
    assign response.chosen_base  = out_reg.base;
    assign response.chosen_size  = out_reg.size;

endmodule

// ===== sim/tb_best_fit_partition_allocator.sv =====
`timescale 1ns / 1ps

module tb_best_fit_partition_allocator;

    localparam int NUM_SLOTS      = bfpa_pkg::DEF_MAX_PARTITIONS;
    localparam int PHASE_ITEMS    = 180;
    localparam int HOLD_AFTER     = 400;
    localparam int HOLD_CYCLES    = 250;
    localparam int IDLE_LIMIT     = 3000;
    localparam int DRAIN_CYCLES   = 3 * (bfpa_pkg::DEF_MAX_PARTITIONS + 2);
    localparam int MAX_REPORTS    = 10;

    // cmd code 3 has no function in the block
    localparam logic [bfpa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [bfpa_pkg::CMD_W-1:0] cmd;
        logic [2:0]                 slot_index;
        logic [15:0]                slot_base;
        logic [15:0]                slot_size;
        logic [15:0]                request_size;
        logic [3:0]                 process_id;
    } alloc_cmd_t;

    typedef struct packed {
        logic [bfpa_pkg::STATUS_W-1:0] status;
        logic [2:0]                    chosen_index;
        logic [15:0]                   chosen_base;
        logic [15:0]                   chosen_size;
    } alloc_outcome_t;

    // Partition table mirror, best-fit prediction and result checking
    class alloc_scoreboard;
        logic [15:0]    base_tab [NUM_SLOTS];
        logic [15:0]    len_tab [NUM_SLOTS];
        logic [3:0]     owner_tab [NUM_SLOTS];
        bit             owned_tab [NUM_SLOTS];
        logic [3:0]     scan_count;
        alloc_outcome_t awaited_outcomes [$];
        int             failures;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                base_tab[i]  = '0;
                len_tab[i]   = '0;
                owner_tab[i] = '0;
                owned_tab[i] = 1'b0;
            end
            scan_count = 4'd8;
            failures   = 0;
        endfunction

        function void set_scan_count(logic [3:0] value);
            scan_count = value;
        endfunction

        function alloc_outcome_t predict_outcome(alloc_cmd_t c);
            alloc_outcome_t r;
            int             limit;
            int             best;
            bit             fits_any;
            bit             found;
            r = '0;
            r.status = bfpa_pkg::ST_OK;
            case (c.cmd)
                bfpa_pkg::CMD_DEFINE:
                begin
                    base_tab[c.slot_index]  = c.slot_base;
                    len_tab[c.slot_index]   = c.slot_size;
                    owner_tab[c.slot_index] = '0;
                    owned_tab[c.slot_index] = 1'b0;
                    r.chosen_index = c.slot_index;
                    r.chosen_base  = c.slot_base;
                    r.chosen_size  = c.slot_size;
                end
                bfpa_pkg::CMD_ALLOC:
                begin
                    limit    = (scan_count > NUM_SLOTS) ? NUM_SLOTS : int'(scan_count);
                    best     = 0;
                    fits_any = 1'b0;
                    found    = 1'b0;
                    for (int i = 0; i < limit; i++)
                    begin
                        if (len_tab[i] >= c.request_size)
                        begin
                            fits_any = 1'b1;
                            if (!owned_tab[i])
                            begin
                                // smallest size, then lowest base, then lowest index
                                if (!found || len_tab[i] < len_tab[best] ||
                                    (len_tab[i] == len_tab[best] && base_tab[i] < base_tab[best]))
                                    best = i;
                                found = 1'b1;
                            end
                        end
                    end
                    if (found)
                    begin
                        owned_tab[best] = 1'b1;
                        owner_tab[best] = c.process_id;
                        r.chosen_index  = best[2:0];
                        r.chosen_base   = base_tab[best];
                        r.chosen_size   = len_tab[best];
                    end
                    else
                        r.status = fits_any ? bfpa_pkg::ST_FULL : bfpa_pkg::ST_TOO_BIG;
                end
                bfpa_pkg::CMD_RELEASE:
                begin
                    // whole table, lowest index first
                    found = 1'b0;
                    for (int i = 0; i < NUM_SLOTS; i++)
                    begin
                        if (!found && owned_tab[i] && owner_tab[i] == c.process_id)
                        begin
                            found          = 1'b1;
                            owned_tab[i]   = 1'b0;
                            owner_tab[i]   = '0;
                            r.chosen_index = i[2:0];
                            r.chosen_base  = base_tab[i];
                            r.chosen_size  = len_tab[i];
                        end
                    end
                    if (!found)
                        r.status = bfpa_pkg::ST_NOT_FOUND;
                end
                default: ;
            endcase
            return r;
        endfunction

        function void accept_command(alloc_cmd_t c);
            awaited_outcomes.push_back(predict_outcome(c));
        endfunction

        function void check_outcome(alloc_outcome_t got);
            alloc_outcome_t want;
            if (awaited_outcomes.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("result with no command pending: status %0d idx %0d %s %h %s %h",
                             got.status, got.chosen_index, "base", got.chosen_base,
                             "size", got.chosen_size);
                return;
            end
            want = awaited_outcomes.pop_front();
            if (got.status !== want.status || got.chosen_index !== want.chosen_index ||
                got.chosen_base !== want.chosen_base || got.chosen_size !== want.chosen_size)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display({"mismatch: expected status %0d idx %0d base %h size %h, ",
                              "got status %0d idx %0d base %h size %h"},
                             want.status, want.chosen_index, want.chosen_base, want.chosen_size,
                             got.status, got.chosen_index, got.chosen_base, got.chosen_size);
            end
        endfunction

        function int pending();
            return awaited_outcomes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bfpa_cmd_if req_if ();
    bfpa_res_if res_if ();
    bfpa_cfg_if setup_if ();

    best_fit_partition_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (res_if),
        .setup    (setup_if)
    );

    alloc_scoreboard sb;
    int              commands_taken;
    int              idle_cycles;
    int              burst_left;
    bit              long_hold_done;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Handshake monitor
    always @(posedge clk)
    begin
        if (req_if.valid && req_if.ready)
        begin
            sb.accept_command({req_if.cmd, req_if.slot_index, req_if.slot_base,
                               req_if.slot_size, req_if.request_size, req_if.process_id});
            commands_taken <= commands_taken + 1;
        end
        if (res_if.valid && res_if.ready)
            sb.check_outcome({res_if.status, res_if.chosen_index, res_if.chosen_base,
                              res_if.chosen_size});
        if (setup_if.valid && setup_if.ready)
            sb.set_scan_count(setup_if.partitions_in_use);
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
            (setup_if.valid && setup_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog on cycles without any transaction
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // Response back-pressure: changing stall patterns plus one long hold-off
    initial
    begin
        int seg_left;
        int mode;
        int phase_cnt;
        res_if.ready = 1'b0;
        seg_left     = 0;
        mode         = 0;
        phase_cnt    = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && commands_taken >= HOLD_AFTER)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(16, 96);
                end
                seg_left--;
                phase_cnt++;
                case (mode)
                    0: res_if.ready <= 1'b1;
                    1: res_if.ready <= 1'($urandom_range(0, 1));
                    2: res_if.ready <= ($urandom_range(0, 3) == 0);
                    default: res_if.ready <= ((phase_cnt % 5) < 2);
                endcase
            end
        end
    end

    function automatic alloc_cmd_t mk_cmd(logic [bfpa_pkg::CMD_W-1:0] cmd, logic [2:0] idx,
                                          logic [15:0] base, logic [15:0] size,
                                          logic [15:0] req, logic [3:0] pid);
        alloc_cmd_t c;
        c.cmd          = cmd;
        c.slot_index   = idx;
        c.slot_base    = base;
        c.slot_size    = size;
        c.request_size = req;
        c.process_id   = pid;
        return c;
    endfunction

    // Mostly a live table with a few owners, some full-range noise
    function automatic alloc_cmd_t random_cmd();
        alloc_cmd_t c;
        int         pick;
        c.cmd          = 2'($urandom_range(0, 3));
        c.slot_index   = 3'($urandom_range(0, 7));
        c.slot_base    = 16'($urandom_range(0, 65535));
        c.slot_size    = 16'($urandom_range(0, 65535));
        c.request_size = 16'($urandom_range(0, 65535));
        c.process_id   = 4'($urandom_range(0, 15));
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            c.cmd = bfpa_pkg::CMD_DEFINE;
            if ($urandom_range(0, 1))
                c.slot_base = 16'($urandom_range(0, 3) * 256);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: c.slot_size = 16'($urandom_range(0, 4) * 64);
                5, 6, 7:       c.slot_size = 16'($urandom_range(0, 1023));
                default: ;
            endcase
        end
        else if (pick < 62)
        begin
            c.cmd = bfpa_pkg::CMD_ALLOC;
            case ($urandom_range(0, 19))
                0, 1, 2:    c.request_size = '0;
                3, 4, 5:    ;
                default:    c.request_size = 16'($urandom_range(0, 300));
            endcase
            if ($urandom_range(0, 4) != 0)
                c.process_id = 4'($urandom_range(0, 3));
        end
        else if (pick < 95)
        begin
            c.cmd = bfpa_pkg::CMD_RELEASE;
            if ($urandom_range(0, 4) != 0)
                c.process_id = 4'($urandom_range(0, 3));
        end
        else
            c.cmd = CMD_UNUSED;
        return c;
    endfunction

    // Offer one command; entered and left at a falling edge
    task automatic issue(input alloc_cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        req_if.valid        <= 1'b1;
        req_if.cmd          <= c.cmd;
        req_if.slot_index   <= c.slot_index;
        req_if.slot_base    <= c.slot_base;
        req_if.slot_size    <= c.slot_size;
        req_if.request_size <= c.request_size;
        req_if.process_id   <= c.process_id;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        burst_left--;
        @(negedge clk);
    endtask

    // Stop offering and wait until every result is back
    task automatic drain();
        req_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_scan_count(input logic [3:0] value);
        setup_if.valid             <= 1'b1;
        setup_if.partitions_in_use <= value;
        @(posedge clk);
        while (!setup_if.ready)
            @(posedge clk);
        @(negedge clk);
        setup_if.valid <= 1'b0;
    endtask

    task automatic run_directed();
        // empty table: zero request fits the size-zero entries
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd5, 16'hFFFF, 16'hFFFF, 16'd0, 4'd15));
        issue(mk_cmd(bfpa_pkg::CMD_RELEASE, 3'd0, 16'd0, 16'd0, 16'd0, 4'd15));
        issue(mk_cmd(bfpa_pkg::CMD_RELEASE, 3'd0, 16'd0, 16'd0, 16'd0, 4'd15));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'd1, 4'd1));
        // size and base ties, extremes of size and base
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd0, 16'h1000, 16'd100, 16'hFFFF, 4'd0));
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd1, 16'hFFFF, 16'hFFFF, 16'd0, 4'd15));
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd2, 16'h0800, 16'd100, 16'd0, 4'd0));
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd3, 16'h0000, 16'd50, 16'd0, 4'd0));
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd4, 16'h0800, 16'd100, 16'd0, 4'd0));
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd5, 16'h2000, 16'd0, 16'd0, 4'd0));
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd6, 16'h3000, 16'd200, 16'd0, 4'd0));
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd7, 16'h0000, 16'hFFFF, 16'd0, 4'd0));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'hFFFF, 4'd1));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'hFFFF, 4'd2));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'hFFFF, 4'd3));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'd100, 4'd4));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'd100, 4'd4));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'd100, 4'd5));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'd60, 4'd6));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'd60, 4'd6));
        issue(mk_cmd(bfpa_pkg::CMD_RELEASE, 3'd0, 16'd0, 16'd0, 16'd0, 4'd4));
        issue(mk_cmd(CMD_UNUSED, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15));
        // redefining an owned entry frees it
        issue(mk_cmd(bfpa_pkg::CMD_DEFINE, 3'd7, 16'hFFFF, 16'hFFFF, 16'd0, 4'd0));
        issue(mk_cmd(bfpa_pkg::CMD_RELEASE, 3'd0, 16'd0, 16'd0, 16'd0, 4'd1));
        issue(mk_cmd(bfpa_pkg::CMD_ALLOC, 3'd0, 16'd0, 16'd0, 16'd0, 4'd0));
    endtask

    task automatic run_random_phase();
        alloc_cmd_t c;
        // populate the whole table first so allocations have something to find
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            c = random_cmd();
            c.cmd        = bfpa_pkg::CMD_DEFINE;
            c.slot_index = i[2:0];
            if ($urandom_range(0, 3) != 0)
                c.slot_size = 16'($urandom_range(0, 400));
            issue(c);
        end
        for (int n = NUM_SLOTS; n < PHASE_ITEMS; n++)
            issue(random_cmd());
    endtask

    // Main sequence: reset, then one phase per scan count setting
    initial
    begin
        logic [3:0] scan_settings [8];
        scan_settings = '{4'd8, 4'd0, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9, 4'd8};
        sb                         = new();
        commands_taken             = 0;
        idle_cycles                = 0;
        burst_left                 = 0;
        long_hold_done             = 1'b0;
        rst_n                      = 1'b0;
        req_if.valid               = 1'b0;
        req_if.cmd                 = bfpa_pkg::CMD_DEFINE;
        req_if.slot_index          = '0;
        req_if.slot_base           = '0;
        req_if.slot_size           = '0;
        req_if.request_size        = '0;
        req_if.process_id          = '0;
        setup_if.valid             = 1'b0;
        setup_if.partitions_in_use = 4'd8;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int p = 0; p < 8; p++)
        begin
            write_scan_count(scan_settings[p]);
            if (p == 0)
                run_directed();
            run_random_phase();
            drain();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bfpa_pkg.sv
rtl/bfpa_ifs.sv
rtl/bfpa_cell.sv
rtl/best_fit_partition_allocator.sv
sim/tb_best_fit_partition_allocator.sv
